// ----- rtl/bhpf_pkg.sv -----
// ---------------------------------------------------------------------------
// bhpf_pkg: shared types and constants for the boiler heat PI core
// Field widths, register codes, reset values and the command word that the
// controller hands to the datapath.
// ---------------------------------------------------------------------------
package bhpf_pkg;

	// field widths
	localparam int DATA_W    = 16;	// Q8.8 temperatures and 16-bit registers
	localparam int DIFF_W    = 17;	// temperature differences, exact
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 40;	// heater power in whole watts
	localparam int FRAC_BITS = 8;

	// shared multiplier: signed 33 x signed 18
	localparam int MA_W   = 33;
	localparam int MB_W   = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int MASS_W = 32;	// inflow_rate * specific_heat

	localparam int INTEGRAL_WIDTH_DEF = 48;

	// register reset values
	localparam logic [DATA_W-1:0] SETPOINT_RST  = 16'd7680;
	localparam logic [DATA_W-1:0] PROP_GAIN_RST = 16'd10000;
	localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 16'd30000;
	localparam logic [DATA_W-1:0] INFLOW_RST    = 16'd256;
	localparam logic [DATA_W-1:0] SPEC_HEAT_RST = 16'd4184;
	localparam logic [DATA_W-1:0] LOSS_COND_RST = 16'd1000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_INFLOW     = 3'd3,
		REG_SPEC_HEAT  = 3'd4,
		REG_LOSS_COND  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] setpoint;	// signed Q8.8
		logic [DATA_W-1:0] prop_gain;
		logic [DATA_W-1:0] integ_gain;
		logic [DATA_W-1:0] inflow_rate;
		logic [DATA_W-1:0] specific_heat;
		logic [DATA_W-1:0] loss_cond;
	} cfg_regs_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_MASS   = 3'd0,	// inflow_rate * specific_heat
		MUL_PROP   = 3'd1,	// prop_gain * error
		MUL_INTEG  = 3'd2,	// integ_gain * error
		MUL_LOSS   = 3'd3,	// loss_cond * (water - air)
		MUL_INFLOW = 3'd4	// mass_heat * (inlet - water)
	} mul_sel_t;

	// accumulator addends
	typedef enum logic [1:0] {
		ADD_LOSS   = 2'd0,
		ADD_INTEG  = 2'd1,
		ADD_INFLOW = 2'd2
	} add_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     mass_load;
		logic     acc_load;
		logic     integ_upd;
		logic     acc_add;
		add_sel_t add_sel;
		logic     out_load;
	} dp_cmd_t;

endpackage

// ----- rtl/bhpf_sample_if.sv -----
// ---------------------------------------------------------------------------
// bhpf_sample_if: temperature sample channel
// One transfer carries air, water and inlet temperature in signed Q8.8.
// ---------------------------------------------------------------------------
interface bhpf_sample_if import bhpf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] air_temp;
	logic signed [DATA_W-1:0] water_temp;
	logic signed [DATA_W-1:0] inlet_temp;

	modport source (output valid, air_temp, water_temp, inlet_temp, input ready);
	modport sink (input valid, air_temp, water_temp, inlet_temp, output ready);
endinterface

// ----- rtl/bhpf_result_if.sv -----
// ---------------------------------------------------------------------------
// bhpf_result_if: heater power channel
// One transfer carries the commanded power and the clip flag.
// ---------------------------------------------------------------------------
interface bhpf_result_if import bhpf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] heat_power;
	logic                    saturated;

	modport source (output valid, heat_power, saturated, input ready);
	modport sink (input valid, heat_power, saturated, output ready);
endinterface

// ----- rtl/bhpf_cfg_if.sv -----
// ---------------------------------------------------------------------------
// bhpf_cfg_if: register write channel
// One transfer writes data into the register selected by index.
// ---------------------------------------------------------------------------
interface bhpf_cfg_if import bhpf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/boiler_heat_pi_feedforward_core.sv -----
// ---------------------------------------------------------------------------
// boiler_heat_pi_feedforward_core: heater power PI controller with feedforward
// Usage:
//   sample: one transfer per measurement (air, water, inlet in signed Q8.8).
//   result: one transfer per sample, heater power in whole watts (40 bit
//           signed) and a flag set when the integral or the output clipped.
//   cfg:    register writes, index 0..5 (setpoint, prop gain, integ gain,
//           inflow rate, specific heat, loss conductance); others ignored.
//           Write only while no sample is in flight; always ready.
// Sequence: the single 33x18 multiplier forms five products in turn, then
//   three accumulator additions follow and the result register loads; a new
//   sample is taken only after the result register has loaded.
// Reset: configuration registers return to their defaults, the integral
//   clears to zero, the result channel goes empty.
// Stall: a waiting result holds while the next sample is taken and worked
//   on; the sequencer then waits until the result register is free.
// ---------------------------------------------------------------------------
module boiler_heat_pi_feedforward_core import bhpf_pkg::*; #(
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	bhpf_sample_if.sink      sample,
	bhpf_result_if.source    result,
	bhpf_cfg_if.sink         cfg
);

	cfg_regs_t regs;
	dp_cmd_t   cmd;

	// configuration registers
	bhpf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// sequencer
	bhpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// arithmetic
	bhpf_dp #(
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.regs       (regs),
		.air_temp   (sample.air_temp),
		.water_temp (sample.water_temp),
		.inlet_temp (sample.inlet_temp),
		.heat_power (result.heat_power),
		.saturated  (result.saturated)
	);

endmodule

// ----- rtl/bhpf_cfg.sv -----
// ---------------------------------------------------------------------------
// bhpf_cfg: configuration register file
// Six 16-bit registers, written one per transfer; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module bhpf_cfg import bhpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bhpf_cfg_if.sink   cfg,
	output cfg_regs_t  regs
);

	cfg_regs_t regs_q;

	// always able to take a write
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.setpoint      <= SETPOINT_RST;
			regs_q.prop_gain     <= PROP_GAIN_RST;
			regs_q.integ_gain    <= INTEG_GAIN_RST;
			regs_q.inflow_rate   <= INFLOW_RST;
			regs_q.specific_heat <= SPEC_HEAT_RST;
			regs_q.loss_cond     <= LOSS_COND_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SETPOINT:   regs_q.setpoint      <= cfg.data;
				REG_PROP_GAIN:  regs_q.prop_gain     <= cfg.data;
				REG_INTEG_GAIN: regs_q.integ_gain    <= cfg.data;
				REG_INFLOW:     regs_q.inflow_rate   <= cfg.data;
				REG_SPEC_HEAT:  regs_q.specific_heat <= cfg.data;
				REG_LOSS_COND:  regs_q.loss_cond     <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/bhpf_ctrl.sv -----
// ---------------------------------------------------------------------------
// bhpf_ctrl: sequencer for the shared multiplier and accumulator
// Walks one sample through five products and three accumulations, then
// loads the output register once the previous result has been taken.
// ---------------------------------------------------------------------------
module bhpf_ctrl import bhpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE       = 9'b000000001,
		ST_MASS       = 9'b000000010,
		ST_PROP       = 9'b000000100,
		ST_INTEG      = 9'b000001000,
		ST_LOSS       = 9'b000010000,
		ST_SUM_LOSS   = 9'b000100000,
		ST_SUM_INTEG  = 9'b001000000,
		ST_SUM_INFLOW = 9'b010000000,
		ST_FINISH     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || out_ready;

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_MASS;
		cmd.add_sel   = ADD_LOSS;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MASS;
				end
			end
			ST_MASS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MASS;
				state_d     = ST_PROP;
			end
			ST_PROP: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_PROP;
				cmd.mass_load = 1'b1;
				state_d       = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_INTEG;
				cmd.acc_load = 1'b1;
				state_d      = ST_LOSS;
			end
			ST_LOSS: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_LOSS;
				cmd.integ_upd = 1'b1;
				state_d       = ST_SUM_LOSS;
			end
			ST_SUM_LOSS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INFLOW;
				cmd.acc_add = 1'b1;
				cmd.add_sel = ADD_LOSS;
				state_d     = ST_SUM_INTEG;
			end
			ST_SUM_INTEG: begin
				cmd.acc_add = 1'b1;
				cmd.add_sel = ADD_INTEG;
				state_d     = ST_SUM_INFLOW;
			end
			ST_SUM_INFLOW: begin
				cmd.acc_add = 1'b1;
				cmd.add_sel = ADD_INFLOW;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/bhpf_dp.sv -----
// ---------------------------------------------------------------------------
// bhpf_dp: datapath with one shared multiplier
// Holds the sample differences, product and accumulator registers, the
// saturating integral and the clamped output register.
// ---------------------------------------------------------------------------
module bhpf_dp import bhpf_pkg::*; #(
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  cfg_regs_t                regs,
	input  logic signed [DATA_W-1:0] air_temp,
	input  logic signed [DATA_W-1:0] water_temp,
	input  logic signed [DATA_W-1:0] inlet_temp,
	output logic signed [OUT_W-1:0]  heat_power,
	output logic                     saturated
);

	// integral update width: holds integral plus one product without overflow
	localparam int IS_W  = ((INTEGRAL_WIDTH > PROD_W) ? INTEGRAL_WIDTH : PROD_W) + 1;
	// accumulator width: integral plus three product-sized terms
	localparam int SUM_W = IS_W + 2;
	localparam int WAT_W = SUM_W - FRAC_BITS;

	localparam logic signed [IS_W-1:0] I_MAX =
		{{(IS_W - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}};
	localparam logic signed [IS_W-1:0] I_MIN = ~I_MAX;
	localparam logic signed [WAT_W-1:0] O_MAX =
		{{(WAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
	localparam logic signed [WAT_W-1:0] O_MIN = ~O_MAX;

	logic signed [DIFF_W-1:0]         err_q, dwa_q, dinw_q;
	logic signed [MA_W-1:0]           op_a;
	logic signed [MB_W-1:0]           op_b;
	logic signed [PROD_W-1:0]         prod_q;
	logic        [MASS_W-1:0]         mass_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic                             iclip_q;
	logic signed [SUM_W-1:0]          acc_q;
	logic signed [SUM_W-1:0]          addend;
	logic signed [IS_W-1:0]           i_sum;
	logic signed [WAT_W-1:0]          watts;
	logic signed [PROD_W-FRAC_BITS-1:0] inflow_fl;
	logic signed [OUT_W-1:0]          heat_q;
	logic                             sat_q;
	logic                             oclip;

	assign heat_power = heat_q;
	assign saturated  = sat_q;

	// sample differences, exact in 17 bits
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			err_q  <= DIFF_W'($signed(regs.setpoint)) - DIFF_W'(water_temp);
			dwa_q  <= DIFF_W'(water_temp) - DIFF_W'(air_temp);
			dinw_q <= DIFF_W'(inlet_temp) - DIFF_W'(water_temp);
		end
	end

	// multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_MASS: begin
				op_a = {{(MA_W - DATA_W){1'b0}}, regs.inflow_rate};
				op_b = {{(MB_W - DATA_W){1'b0}}, regs.specific_heat};
			end
			MUL_PROP: begin
				op_a = {{(MA_W - DATA_W){1'b0}}, regs.prop_gain};
				op_b = MB_W'(err_q);
			end
			MUL_INTEG: begin
				op_a = {{(MA_W - DATA_W){1'b0}}, regs.integ_gain};
				op_b = MB_W'(err_q);
			end
			MUL_LOSS: begin
				op_a = {{(MA_W - DATA_W){1'b0}}, regs.loss_cond};
				op_b = MB_W'(dwa_q);
			end
			MUL_INFLOW: begin
				op_a = {{(MA_W - MASS_W){1'b0}}, mass_q};
				op_b = MB_W'(dinw_q);
			end
			default: ;
		endcase
	end

	// product register and mass-heat hold
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.mass_load) begin
			mass_q <= prod_q[MASS_W-1:0];
		end
	end

	// saturating integral
	assign i_sum = IS_W'(integ_q) + IS_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			iclip_q <= 1'b0;
		end else if (cmd.integ_upd) begin
			if (i_sum > I_MAX) begin
				integ_q <= INTEGRAL_WIDTH'(I_MAX);
				iclip_q <= 1'b1;
			end else if (i_sum < I_MIN) begin
				integ_q <= INTEGRAL_WIDTH'(I_MIN);
				iclip_q <= 1'b1;
			end else begin
				integ_q <= INTEGRAL_WIDTH'(i_sum);
				iclip_q <= 1'b0;
			end
		end
	end

	// inflow term reduced to Q.8 by floor: drop the low fraction bits
	assign inflow_fl = prod_q[PROD_W-1:FRAC_BITS];

	// accumulator addend
	always_comb begin
		addend = '0;
		case (cmd.add_sel)
			ADD_LOSS:   addend = SUM_W'(prod_q);
			ADD_INTEG:  addend = SUM_W'(integ_q);
			ADD_INFLOW: addend = -SUM_W'(inflow_fl);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			acc_q <= SUM_W'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + addend;
		end
	end

	// whole watts, clamped to the output width
	assign watts = WAT_W'(acc_q >>> FRAC_BITS);
	assign oclip = (watts > O_MAX) || (watts < O_MIN);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (watts > O_MAX) begin
				heat_q <= OUT_W'(O_MAX);
			end else if (watts < O_MIN) begin
				heat_q <= OUT_W'(O_MIN);
			end else begin
				heat_q <= OUT_W'(watts);
			end
			sat_q <= iclip_q || oclip;
		end
	end

endmodule
